### rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// holds transfer payload structs, operation and status codes and the cell command type
// no dependencies
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ID_BITS      = 8;
	localparam int PRIO_BITS    = 16;
	localparam int COUNT_BITS   = 5;

	// operation codes carried in the func field
	localparam logic [1:0] FUNC_ENQ = 2'd0;
	localparam logic [1:0] FUNC_DEQ = 2'd1;
	localparam logic [1:0] FUNC_UPD = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]                  func;
		logic [ID_BITS-1:0]          entry_id;
		logic signed [PRIO_BITS-1:0] priority_in;
	} spq_req_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    popped_id;
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] entry_count;
	} spq_rsp_t;

	// what every cell of the row does
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                    op;
		logic [ID_BITS-1:0]          id;
		logic signed [PRIO_BITS-1:0] prio;
	} cell_cmd_t;

	// contents of one slot as seen by its neighbours
	typedef struct packed {
		logic                        valid;
		logic [ID_BITS-1:0]          id;
		logic signed [PRIO_BITS-1:0] prio;
	} slot_t;

endpackage

### rtl/spq_cell.sv
// spq_cell: one slot of the sorted row
// compares against the broadcast key and takes data from itself, the key or a neighbour
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  slot_t     left,
	input  logic      left_ge,
	input  slot_t     right,
	input  logic      rm_in,
	output slot_t     own,
	output logic      ge,
	output logic      rm_out
);

	logic                        valid_q;
	logic [ID_BITS-1:0]          id_q;
	logic signed [PRIO_BITS-1:0] prio_q;
	slot_t                       nxt;
	logic                        match;

	// entry stays ahead of the key: greater or equal priority, older wins ties
	assign ge     = valid_q && ($signed(prio_q) >= $signed(cmd.prio));
	assign match  = valid_q && (id_q == cmd.id);
	// first match at or before this cell
	assign rm_out = rm_in || match;

	assign own.valid = valid_q;
	assign own.id    = id_q;
	assign own.prio  = prio_q;

	always_comb begin
		nxt = own;
		unique case (cmd.op)
			CELL_HOLD: begin
				nxt = own;
			end
			CELL_INSERT: begin
				if (!ge) begin
					if (left_ge) begin
						nxt.valid = 1'b1;
						nxt.id    = cmd.id;
						nxt.prio  = cmd.prio;
					end else begin
						nxt = left;
					end
				end
			end
			CELL_POP: begin
				nxt = right;
			end
			CELL_REMOVE: begin
				if (rm_out) begin
					nxt = right;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= nxt.id;
		prio_q <= nxt.prio;
	end

endmodule

### rtl/sorted_priority_queue_core.sv
// sorted_priority_queue_core: top level of the sorted priority queue
// a row of spq_cell slots plus transfer control and the entry counter
// depends on spq_pkg and spq_cell
//
// usage
// - request channel (req_valid, req_stall, req): func, entry_id, priority_in
// - response channel (rsp_valid, rsp_stall, rsp): popped_id, status, entry_count
// - a request transfers on a clock edge with req_valid high and req_stall low;
//   every request yields exactly one response, in request order
// - enqueue and dequeue make a single pass of the cell row; the response is
//   registered and shows the cycle after the transfer, and a new request is
//   taken every cycle while responses drain
// - update makes a remove pass over the row, then an insert pass;
//   req_stall is high while the insert pass is pending, so no new request is
//   taken until it is done; the response shows after the insert pass
// - throughput is set by the single shared row: every cell compares and
//   shifts once per cycle, one operation per pass
// - while the response register holds an untaken response and rsp_stall is
//   high, req_stall is high and the row holds still
// - reset empties the queue at once (all slot valid bits and the counter clear);
//   no clearing pass, requests are taken from the first cycle after reset
// - entry_count reports the number of entries after the operation
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output spq_rsp_t rsp
);

	localparam int COUNT_W = $clog2(CAPACITY + 1);

	// cell row wiring
	cell_cmd_t   cmd;
	slot_t       slots [CAPACITY];
	logic        ge    [CAPACITY];
	logic        rm    [CAPACITY];

	// control state
	logic                        upd_q;       // insert pass of an update pending
	logic [ID_BITS-1:0]          upd_id_q;
	logic signed [PRIO_BITS-1:0] upd_prio_q;
	logic [COUNT_W-1:0]          cnt_q;
	logic [COUNT_W-1:0]          cnt_d;
	logic                        rsp_valid_q;
	spq_rsp_t                    rsp_q;
	spq_rsp_t                    rsp_d;

	logic out_free;
	logic req_fire;
	logic upd_fire;
	logic produce;
	logic full;
	logic empty;
	logic found;

	assign full     = (cnt_q == COUNT_W'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign found    = rm[CAPACITY-1];

	// response register free this cycle, either empty or draining
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = upd_q || !out_free;
	assign req_fire  = req_valid && !req_stall;
	assign upd_fire  = upd_q && out_free;

	// command broadcast to every cell
	always_comb begin
		cmd.op   = CELL_HOLD;
		cmd.id   = req.entry_id;
		cmd.prio = req.priority_in;
		if (upd_q) begin
			cmd.id   = upd_id_q;
			cmd.prio = upd_prio_q;
			if (upd_fire && !full) begin
				cmd.op = CELL_INSERT;
			end
		end else if (req_fire) begin
			unique case (req.func)
				FUNC_ENQ: cmd.op = full  ? CELL_HOLD : CELL_INSERT;
				FUNC_DEQ: cmd.op = empty ? CELL_HOLD : CELL_POP;
				FUNC_UPD: cmd.op = CELL_REMOVE;
				default:  cmd.op = CELL_HOLD;
			endcase
		end
	end

	// the row of slots, head in cell 0
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		slot_t left_s;
		slot_t right_s;
		logic  left_ge_s;
		logic  rm_in_s;

		if (k == 0) begin : g_head
			assign left_s    = '0;
			assign left_ge_s = 1'b1;
			assign rm_in_s   = 1'b0;
		end else begin : g_body
			assign left_s    = slots[k-1];
			assign left_ge_s = ge[k-1];
			assign rm_in_s   = rm[k-1];
		end

		if (k == CAPACITY - 1) begin : g_tail
			assign right_s = '0;
		end else begin : g_mid
			assign right_s = slots[k+1];
		end

		spq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.left    (left_s),
			.left_ge (left_ge_s),
			.right   (right_s),
			.rm_in   (rm_in_s),
			.own     (slots[k]),
			.ge      (ge[k]),
			.rm_out  (rm[k])
		);
	end

	// next count and response contents
	always_comb begin
		cnt_d             = cnt_q;
		produce           = 1'b0;
		rsp_d.popped_id   = '0;
		rsp_d.status      = ST_OK;
		if (upd_fire) begin
			produce = 1'b1;
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				cnt_d = cnt_q + COUNT_W'(1);
			end
		end else if (req_fire) begin
			unique case (req.func)
				FUNC_ENQ: begin
					produce = 1'b1;
					if (full) begin
						rsp_d.status = ST_FULL;
					end else begin
						cnt_d = cnt_q + COUNT_W'(1);
					end
				end
				FUNC_DEQ: begin
					produce = 1'b1;
					if (empty) begin
						rsp_d.status = ST_EMPTY;
					end else begin
						rsp_d.popped_id = slots[0].id;
						cnt_d           = cnt_q - COUNT_W'(1);
					end
				end
				FUNC_UPD: begin
					// remove pass; the response follows the insert pass
					if (found) begin
						cnt_d = cnt_q - COUNT_W'(1);
					end
				end
				default: begin
					produce = 1'b1;
				end
			endcase
		end
		rsp_d.entry_count = COUNT_BITS'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q       <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (req_fire && req.func == FUNC_UPD) begin
				upd_q <= 1'b1;
			end else if (upd_fire) begin
				upd_q <= 1'b0;
			end
			if (produce) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			upd_id_q   <= req.entry_id;
			upd_prio_q <= req.priority_in;
		end
		if (produce) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/spq_check.sv
// spq_check: port-level assertions for sorted_priority_queue_core
// attached to the top level by the bind statement at the end of this file
// depends on spq_pkg
module spq_check import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input spq_req_t req,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input spq_rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// an accepted update stalls requests in the next cycle while its insert pass is pending
	a_upd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.func == FUNC_UPD |=> req_stall)
		else $error("request taken during update insert pass");

	// empty status only on an empty queue with no id
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.entry_count == '0 && rsp.popped_id == '0)
		else $error("empty status with entries or id");

	// full status only with the queue at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == COUNT_BITS'(CAPACITY))
		else $error("full status below capacity");

endmodule

bind sorted_priority_queue_core spq_check #(.CAPACITY(CAPACITY)) u_spq_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/sv/tb_sorted_priority_queue_core.sv
`timescale 1ns / 100ps
// tb_sorted_priority_queue_core: self-checking testbench for the sorted priority queue
// keeps a shadow copy of the sorted list to predict every response, with random idling
// depends on spq_pkg and sorted_priority_queue_core
module tb_sorted_priority_queue_core;
	import spq_pkg::*;

	localparam int DEPTH = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 300000;
	// the func field has one code with no operation behind it
	localparam logic [1:0] FUNC_NONE = 2'd3;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	spq_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	spq_rsp_t rsp;

	// shadow of the sorted list, slot 0 is the head
	logic [ID_BITS-1:0]          shadow_id [DEPTH];
	logic signed [PRIO_BITS-1:0] shadow_prio [DEPTH];
	int unsigned                 shadow_count = 0;

	// responses still owed by the block, oldest first
	spq_rsp_t pending_rsp [$];
	spq_rsp_t want;

	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit          idle_on = 1'b0;
	int          hold_off = 0;
	int          stall_left = 0;

	sorted_priority_queue_core #(
		.CAPACITY(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------
	// shadow list
	// ---------------------------------------------------------------------------

	// close the gap left by the entry at pos
	function automatic void drop_slot(input int unsigned pos);
		for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
			shadow_id[k]   = shadow_id[k + 1];
			shadow_prio[k] = shadow_prio[k + 1];
		end
		shadow_count--;
	endfunction

	// insert behind every entry of greater or equal priority; 0 when full
	function automatic bit place_entry(input logic [ID_BITS-1:0] id,
			input logic signed [PRIO_BITS-1:0] prio);
		int unsigned pos = 0;
		if (shadow_count >= DEPTH)
			return 1'b0;
		while (pos < shadow_count && shadow_prio[pos] >= prio)
			pos++;
		for (int unsigned k = shadow_count; k > pos; k--) begin
			shadow_id[k]   = shadow_id[k - 1];
			shadow_prio[k] = shadow_prio[k - 1];
		end
		shadow_id[pos]   = id;
		shadow_prio[pos] = prio;
		shadow_count++;
		return 1'b1;
	endfunction

	// apply one request to the shadow list and return the response it must give
	function automatic spq_rsp_t serve_request(input spq_req_t item);
		spq_rsp_t out;
		out = '0;
		out.status = ST_OK;
		case (item.func)
			FUNC_ENQ: begin
				if (!place_entry(item.entry_id, item.priority_in))
					out.status = ST_FULL;
			end
			FUNC_DEQ: begin
				if (shadow_count == 0) begin
					out.status = ST_EMPTY;
				end else begin
					out.popped_id = shadow_id[0];
					drop_slot(0);
				end
			end
			FUNC_UPD: begin
				// only the first match from the head leaves
				for (int unsigned k = 0; k < shadow_count; k++) begin
					if (shadow_id[k] == item.entry_id) begin
						drop_slot(k);
						break;
					end
				end
				if (!place_entry(item.entry_id, item.priority_in))
					out.status = ST_FULL;
			end
			default: begin
			end
		endcase
		out.entry_count = COUNT_BITS'(shadow_count);
		return out;
	endfunction

	// ---------------------------------------------------------------------------
	// response side: stall generator and checker
	// ---------------------------------------------------------------------------

	// a long hold-off takes priority over the random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// values read here are those from before the edge, so the order of
	// processes within the step does not matter
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response with none outstanding: popped_id %0d status %0d count %0d",
					rsp.popped_id, rsp.status, rsp.entry_count);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.popped_id !== want.popped_id) begin
					$error("popped_id: expected %0d, got %0d", want.popped_id, rsp.popped_id);
					errors++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, rsp.entry_count);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------------------

	function automatic spq_req_t make_req(input logic [1:0] f, input logic [ID_BITS-1:0] id,
			input logic signed [PRIO_BITS-1:0] prio);
		spq_req_t r;
		r.func        = f;
		r.entry_id    = id;
		r.priority_in = prio;
		return r;
	endfunction

	// offer one request and hold it until the transfer; valid stays high after
	// return, so the caller either sends again or lowers it at the next falling edge
	task automatic send_request(input spq_req_t item);
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(serve_request(item));
	endtask

	task automatic hold_request(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	// sender pauses until every owed response is in
	task automatic wait_drained();
		hold_request(1);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// priorities lean towards extremes and a small set of tied values
	function automatic logic signed [PRIO_BITS-1:0] random_prio();
		logic signed [PRIO_BITS-1:0] p;
		int                          step;
		case ($urandom_range(0, 5))
			0: p = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1, 2: begin
				step = int'($urandom_range(0, 4)) - 2;
				p    = PRIO_BITS'(step * 256);
			end
			default: p = PRIO_BITS'($urandom_range(0, 65535));
		endcase
		return p;
	endfunction

	// fill_pct sets the share of enqueues; dequeues take what the rest leaves
	function automatic spq_req_t random_req(input int unsigned fill_pct);
		spq_req_t r;
		int unsigned pick;
		if ($urandom_range(0, 3) == 0)
			r.entry_id = ID_BITS'($urandom_range(0, 255));
		else
			r.entry_id = ID_BITS'($urandom_range(0, 15));
		r.priority_in = random_prio();
		pick = $urandom_range(0, 99);
		if (pick < 2)
			r.func = FUNC_NONE;
		else if (pick < 2 + fill_pct)
			r.func = FUNC_ENQ;
		else if (pick < 27 + fill_pct)
			r.func = FUNC_UPD;
		else
			r.func = FUNC_DEQ;
		// most updates aim at an id that is held now
		if (r.func == FUNC_UPD && shadow_count > 0 && $urandom_range(0, 3) != 0)
			r.entry_id = shadow_id[$urandom_range(0, shadow_count - 1)];
		return r;
	endfunction

	task automatic random_run(input int unsigned n);
		int unsigned fill_pct;
		fill_pct = 48;
		for (int unsigned i = 0; i < n; i++) begin
			// change the mix now and then so the list swings between empty and full
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: fill_pct = 20;
					1: fill_pct = 48;
					default: fill_pct = 65;
				endcase
			end
			if (idle_on && $urandom_range(0, 7) == 0)
				hold_request($urandom_range(1, 10));
			send_request(random_req(fill_pct));
		end
	endtask

	// ---------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------

	// dequeue and the spare code on an empty list
	task automatic test_empty_queue();
		send_request(make_req(FUNC_DEQ, 8'h5a, 16'sh1234));
		send_request(make_req(FUNC_NONE, 8'ha5, 16'shedcb));
	endtask

	// fill to capacity with extreme fields, tied priorities and a repeated id
	task automatic test_fill_and_ties();
		send_request(make_req(FUNC_ENQ, 8'h00, 16'sh8000));
		send_request(make_req(FUNC_ENQ, 8'hff, 16'sh7fff));
		send_request(make_req(FUNC_ENQ, 8'd1, 16'sh0100));
		send_request(make_req(FUNC_ENQ, 8'd2, 16'sh0100));
		send_request(make_req(FUNC_ENQ, 8'd3, 16'sh0100));
		send_request(make_req(FUNC_ENQ, 8'd4, 16'shff00));
		send_request(make_req(FUNC_ENQ, 8'd5, 16'sh0000));
		send_request(make_req(FUNC_ENQ, 8'd6, 16'shffff));
		send_request(make_req(FUNC_ENQ, 8'd7, 16'sh0001));
		send_request(make_req(FUNC_ENQ, 8'h80, 16'sh7fff));
		send_request(make_req(FUNC_ENQ, 8'd9, 16'sh8000));
		send_request(make_req(FUNC_ENQ, 8'd10, 16'sh1234));
		send_request(make_req(FUNC_ENQ, 8'd11, 16'shedcc));
		send_request(make_req(FUNC_ENQ, 8'd12, 16'sh0100));
		send_request(make_req(FUNC_ENQ, 8'd1, 16'sh0200));
		send_request(make_req(FUNC_ENQ, 8'd13, 16'sh4000));
	endtask

	// full list: dropped enqueue, dropped update of an absent id, update of a
	// held id that frees its own slot first, the spare code, then a couple of dequeues
	task automatic test_full_queue();
		send_request(make_req(FUNC_ENQ, 8'd20, 16'sh0500));
		send_request(make_req(FUNC_UPD, 8'd99, 16'sh0000));
		send_request(make_req(FUNC_UPD, 8'd1, 16'shc000));
		send_request(make_req(FUNC_NONE, 8'hff, 16'sh7fff));
		send_request(make_req(FUNC_DEQ, 8'h00, 16'sh0000));
		send_request(make_req(FUNC_DEQ, 8'hff, 16'shffff));
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		hold_off = 60;
		for (int unsigned i = 0; i < 24; i++)
			send_request(random_req(48));
		wait_drained();
	endtask

	task automatic test_random_mix();
		idle_on = 1'b1;
		random_run(720);
		wait_drained();
	endtask

	// closing stretch with both sides flat out
	task automatic test_random_no_idle();
		idle_on = 1'b0;
		random_run(80);
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_fill_and_ties();
		test_full_queue();
		wait_drained();
		test_backpressure();
		test_random_mix();
		test_random_no_idle();

		// keep the clock running to catch any stray response
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_check.sv
tb/sv/tb_sorted_priority_queue_core.sv
